// File: sv/mpfb_pkg.sv
`default_nettype none
package mpfb_pkg;

    localparam int DefWidth      = 128;
    localparam int DefHeight     = 64;
    localparam int DefQueueDepth = 2;
    // covers the largest store over the parameter range (256 x 16 pages)
    localparam int CmdAddrW      = 12;

    typedef enum logic [1:0] {
        FN_DRAW  = 2'd0,
        FN_CLEAR = 2'd1,
        FN_READ  = 2'd2,
        FN_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        COL_BLACK   = 2'd0,
        COL_WHITE   = 2'd1,
        COL_INVERSE = 2'd2,
        COL_NONE    = 2'd3
    } t_color;

    typedef enum logic [1:0] {
        K_DRAW = 2'd0,
        K_FILL = 2'd1,
        K_READ = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        t_color              color;
        logic                zero;   // read past the store
        logic [7:0]          bits;   // pixel mask or fill byte
        logic [CmdAddrW-1:0] addr;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef enum logic [2:0] {
        B_INIT = 3'd0,
        B_IDLE = 3'd1,
        B_RMW  = 3'd2,
        B_READ = 3'd3,
        B_FILL = 3'd4
    } t_bstate;

endpackage
`default_nettype wire

// File: sv/mono_page_framebuffer_unit.sv
// Page-organized monochrome framebuffer, WIDTH x HEIGHT pixels, one byte per
// column of eight rows in a page.
// Request channel: an operation is taken at a rising edge with start high and
// busy low. i_func selects draw pixel, clear screen, read byte or none; the other
// fields are sampled with it. Requests go into a small queue and are
// executed in order by the store sequencer.
// Result channel: a read gives one byte on o_read_data, marked by o_strobe
// for exactly one cycle; it must be taken then, there is no stall.
// Sequencing: a read is queued, then popped while its byte is registered
// from the store, and shown in the read state. Reads run at 1 per cycle
// while they follow each other in the queue; a draw takes a dispatch step
// and a modify step (read-modify-write of the store), and a clear writes
// every store byte in turn. busy rises while the queue is full.
// Reset: the store is cleared to zero by a pass over all WIDTH*ceil(HEIGHT/8)
// bytes (1024 at default size), one byte per cycle; busy stays high throughout.
`default_nettype none
module mono_page_framebuffer_unit import mpfb_pkg::*; #(
    parameter int WIDTH       = DefWidth,
    parameter int HEIGHT      = DefHeight,
    parameter int QUEUE_DEPTH = DefQueueDepth
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_x_pos,
    input  wire logic signed [15:0] i_y_pos,
    input  wire logic [1:0]         i_color,
    input  wire logic [9:0]         i_byte_index,
    output logic                    o_strobe,
    output logic [7:0]              o_read_data
);

    logic    accept;
    logic    push;
    logic    pop;
    logic    init;
    t_cmd    cmd;
    t_cmd    head;
    t_q_stat q_stat;

    assign busy   = q_stat.full || init;
    assign accept = start && !busy;

    mpfb_front #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_front (
        .i_accept     (accept),
        .i_func       (i_func),
        .i_x_pos      (i_x_pos),
        .i_y_pos      (i_y_pos),
        .i_color      (i_color),
        .i_byte_index (i_byte_index),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    mpfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    mpfb_back #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (q_stat),
        .i_head      (head),
        .o_pop       (pop),
        .o_init      (init),
        .o_strobe    (o_strobe),
        .o_read_data (o_read_data)
    );

endmodule
`default_nettype wire

// File: sv/mpfb_front.sv
`default_nettype none
module mpfb_front import mpfb_pkg::*; #(
    parameter int WIDTH  = DefWidth,
    parameter int HEIGHT = DefHeight
) (
    input  wire logic               i_accept,
    input  wire logic [1:0]         i_func,
    input  wire logic signed [15:0] i_x_pos,
    input  wire logic signed [15:0] i_y_pos,
    input  wire logic [1:0]         i_color,
    input  wire logic [9:0]         i_byte_index,
    output logic                    o_push,
    output t_cmd                    o_cmd
);

    localparam int Pages      = (HEIGHT + 7) / 8;
    localparam int StoreBytes = WIDTH * Pages;
    // one bit above the address so the full store size is representable
    localparam int IdxW       = CmdAddrW + 1;

    always_comb begin
        t_func               fn;
        t_color              col;
        logic                x_in;
        logic                y_in;
        logic                idx_ok;
        logic                keep;
        logic [CmdAddrW-1:0] page_base;
        fn        = t_func'(i_func);
        col       = t_color'(i_color);
        x_in      = !i_x_pos[15] && (i_x_pos[14:0] < 15'(WIDTH));
        y_in      = !i_y_pos[15] && (i_y_pos[14:0] < 15'(HEIGHT));
        idx_ok    = IdxW'(i_byte_index) < IdxW'(StoreBytes);
        page_base = CmdAddrW'(i_y_pos[14:3]) * CmdAddrW'(WIDTH);
        keep      = 1'b0;
        o_cmd       = '0;
        o_cmd.color = col;
        unique case (fn)
            FN_DRAW: begin
                keep       = x_in && y_in && (col != COL_NONE);
                o_cmd.kind = K_DRAW;
                o_cmd.bits = 8'(1) << i_y_pos[2:0];
                o_cmd.addr = CmdAddrW'(i_x_pos[14:0]) + page_base;
            end
            FN_CLEAR: begin
                keep       = (col == COL_BLACK) || (col == COL_WHITE);
                o_cmd.kind = K_FILL;
                o_cmd.bits = (col == COL_WHITE) ? 8'hFF : 8'h00;
            end
            FN_READ: begin
                keep       = 1'b1;
                o_cmd.kind = K_READ;
                o_cmd.zero = !idx_ok;
                o_cmd.addr = CmdAddrW'(i_byte_index);
            end
            FN_NONE: begin
                keep = 1'b0;
            end
        endcase
        o_push = i_accept && keep;
    end

endmodule
`default_nettype wire

// File: sv/mpfb_queue.sv
`default_nettype none
module mpfb_queue import mpfb_pkg::*; #(
    parameter int DEPTH = DefQueueDepth
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_data,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_cmd            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_count, n_count;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CntW'(DEPTH));

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CntW'(DEPTH)))
        else $error("request pushed into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("request popped from empty queue");
`endif

endmodule
`default_nettype wire

// File: sv/mpfb_back.sv
`default_nettype none
module mpfb_back import mpfb_pkg::*; #(
    parameter int WIDTH  = DefWidth,
    parameter int HEIGHT = DefHeight
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_q_stat i_stat,
    input  wire t_cmd    i_head,
    output logic         o_pop,
    output logic         o_init,
    output logic         o_strobe,
    output logic [7:0]   o_read_data
);

    localparam int Pages      = (HEIGHT + 7) / 8;
    localparam int StoreBytes = WIDTH * Pages;
    localparam int AW         = $clog2(StoreBytes);

    t_bstate       r_state, n_state;
    t_cmd          r_cmd;
    logic [AW-1:0] r_cnt, n_cnt;
    logic [7:0]    r_rdata;
    logic [7:0]    mem [StoreBytes];

    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic          last;

    function automatic logic [7:0] apply_draw(input logic [7:0] old,
                                              input logic [7:0] mask,
                                              input t_color     col);
        logic [7:0] res;
        unique case (col)
            COL_WHITE:   res = old | mask;
            COL_BLACK:   res = old & ~mask;
            COL_INVERSE: res = old ^ mask;
            COL_NONE:    res = old;
        endcase
        return res;
    endfunction

    assign last  = (r_cnt == AW'(StoreBytes - 1));
    assign raddr = i_head.addr[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            B_INIT, B_FILL: begin
                n_cnt = last ? '0 : r_cnt + 1'b1;
                if (last) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE, B_READ: begin
                n_state = B_IDLE;
                if (!i_stat.empty) begin
                    unique case (i_head.kind)
                        K_DRAW:  n_state = B_RMW;
                        K_FILL:  n_state = B_FILL;
                        K_READ:  n_state = B_READ;
                        default: n_state = B_IDLE;
                    endcase
                end
            end
            B_RMW: begin
                n_state = B_IDLE;
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_pop       = 1'b0;
        o_init      = 1'b0;
        o_strobe    = 1'b0;
        o_read_data = 8'h00;
        we          = 1'b0;
        waddr       = r_cnt;
        wdata       = 8'h00;
        unique case (r_state)
            B_INIT: begin
                o_init = 1'b1;
                we     = 1'b1;
            end
            B_FILL: begin
                we    = 1'b1;
                wdata = r_cmd.bits;
            end
            B_RMW: begin
                we    = 1'b1;
                waddr = r_cmd.addr[AW-1:0];
                wdata = apply_draw(r_rdata, r_cmd.bits, r_cmd.color);
            end
            B_READ: begin
                o_pop       = !i_stat.empty;
                o_strobe    = 1'b1;
                o_read_data = r_cmd.zero ? 8'h00 : r_rdata;
            end
            B_IDLE: begin
                o_pop = !i_stat.empty;
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

`ifndef SYNTHESIS
    a_read_follows_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_READ) |-> $past(o_pop))
        else $error("read result without popped request");
    a_rmw_from_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_RMW) |-> $past(r_state == B_IDLE || r_state == B_READ))
        else $error("modify cycle not preceded by dispatch");
    a_init_queue_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_init |-> i_stat.empty)
        else $error("request queued during clearing pass");
`endif

endmodule
`default_nettype wire

// File: dv/mpfb_frame_check.sv
`timescale 1ns / 1ps
module mpfb_frame_check import mpfb_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_busy,
    input  wire t_func              i_func,
    input  wire logic signed [15:0] i_x_pos,
    input  wire logic signed [15:0] i_y_pos,
    input  wire t_color             i_color,
    input  wire logic [9:0]         i_byte_index,
    input  wire logic               i_strobe,
    input  wire logic [7:0]         i_read_data,
    output int                      o_mismatch_count,
    output int                      o_reads_outstanding
);

    localparam int FbWidth    = DefWidth;
    localparam int FbHeight   = DefHeight;
    localparam int StoreBytes = FbWidth * ((FbHeight + 7) / 8);

    logic [7:0] shadow_frame [StoreBytes];
    logic [7:0] read_data_expected [$];
    logic [7:0] oldest_read;
    int         mismatches = 0;

    assign o_mismatch_count = mismatches;

    task automatic apply_request(t_func fn, logic signed [15:0] x, logic signed [15:0] y,
                                 t_color col, logic [9:0] idx);
        int         addr;
        logic [7:0] mask;
        case (fn)
            FN_DRAW: begin
                if (x >= 0 && x < FbWidth && y >= 0 && y < FbHeight) begin
                    addr = int'(x) + (int'(y) / 8) * FbWidth;
                    mask = 8'(1 << y[2:0]);
                    case (col)
                        COL_WHITE:   shadow_frame[addr] = shadow_frame[addr] | mask;
                        COL_BLACK:   shadow_frame[addr] = shadow_frame[addr] & ~mask;
                        COL_INVERSE: shadow_frame[addr] = shadow_frame[addr] ^ mask;
                        default: ;
                    endcase
                end
            end
            FN_CLEAR: begin
                if (col == COL_WHITE) begin
                    foreach (shadow_frame[i]) shadow_frame[i] = 8'hFF;
                end else if (col == COL_BLACK) begin
                    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
                end
            end
            FN_READ: begin
                if (int'(idx) < StoreBytes) begin
                    read_data_expected.push_back(shadow_frame[idx]);
                end else begin
                    read_data_expected.push_back(8'h00);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
            read_data_expected.delete();
        end else begin
            if (i_strobe) begin
                if (read_data_expected.size() == 0) begin
                    $error("read_data: no read pending, actual %02h", i_read_data);
                    mismatches++;
                end else begin
                    oldest_read = read_data_expected.pop_front();
                    if (i_read_data !== oldest_read) begin
                        $error("read_data: expected %02h, actual %02h", oldest_read,
                               i_read_data);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                apply_request(i_func, i_x_pos, i_y_pos, i_color, i_byte_index);
            end
        end
        o_reads_outstanding <= read_data_expected.size();
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
module testbench import mpfb_pkg::*;;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_func              func = FN_DRAW;
    logic signed [15:0] x_pos = '0;
    logic signed [15:0] y_pos = '0;
    t_color             color = COL_BLACK;
    logic [9:0]         byte_index = '0;
    logic               strobe;
    logic [7:0]         read_data;
    int                 mismatch_count;
    int                 reads_outstanding;

    int                 quiet_run = 0;
    int                 clears_left = 30;
    int                 sent_requests = 0;
    int                 settle;
    int                 pick;
    t_func              fn;
    t_color             col;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [9:0]         idx;
    logic [9:0]         drawn_bytes [$];

    always #2 i_clk = ~i_clk;

    mono_page_framebuffer_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (func),
        .i_x_pos      (x_pos),
        .i_y_pos      (y_pos),
        .i_color      (color),
        .i_byte_index (byte_index),
        .o_strobe     (strobe),
        .o_read_data  (read_data)
    );

    mpfb_frame_check frame_check (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_start             (start),
        .i_busy              (busy),
        .i_func              (func),
        .i_x_pos             (x_pos),
        .i_y_pos             (y_pos),
        .i_color             (color),
        .i_byte_index        (byte_index),
        .i_strobe            (strobe),
        .i_read_data         (read_data),
        .o_mismatch_count    (mismatch_count),
        .o_reads_outstanding (reads_outstanding)
    );

    task automatic send_request(t_func f, logic signed [15:0] px, logic signed [15:0] py,
                                t_color c, logic [9:0] bi);
        int gap;
        if (quiet_run > 0) begin
            gap = 0;
            quiet_run--;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 29) == 0) quiet_run = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        func       <= f;
        x_pos      <= px;
        y_pos      <= py;
        color      <= c;
        byte_index <= bi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // mostly on screen, some at the edges, some anywhere in the 16-bit range
    function automatic logic signed [15:0] pick_coordinate(int span);
        int r;
        r = $urandom_range(0, 9);
        if (r < 8) return 16'($urandom_range(0, span - 1));
        if (r == 8) begin
            case ($urandom_range(0, 3))
                0: return -16'sd1;
                1: return 16'sd0;
                2: return 16'(span - 1);
                default: return 16'(span);
            endcase
        end
        return 16'($urandom);
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(FN_READ, 0, 0, COL_BLACK, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd1023);
        send_request(FN_DRAW, 0, 0, COL_WHITE, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd0);
        send_request(FN_DRAW, 127, 63, COL_WHITE, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd1023);
        send_request(FN_DRAW, 0, 0, COL_INVERSE, 10'd0);
        send_request(FN_DRAW, 0, 7, COL_INVERSE, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd0);
        send_request(FN_DRAW, 127, 63, COL_BLACK, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd1023);
        // off-screen draws and a draw with no colour
        send_request(FN_DRAW, -1, 0, COL_WHITE, 10'd0);
        send_request(FN_DRAW, 128, 0, COL_WHITE, 10'd0);
        send_request(FN_DRAW, 0, 64, COL_WHITE, 10'd0);
        send_request(FN_DRAW, -32768, 32767, COL_WHITE, 10'd0);
        send_request(FN_DRAW, 32767, -32768, COL_INVERSE, 10'd0);
        send_request(FN_DRAW, 5, 5, COL_NONE, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd5);
        send_request(FN_NONE, -1, -1, COL_WHITE, 10'd1023);
        send_request(FN_CLEAR, 0, 0, COL_WHITE, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd517);
        send_request(FN_CLEAR, 0, 0, COL_INVERSE, 10'd0);
        send_request(FN_CLEAR, 0, 0, COL_NONE, 10'd0);
        send_request(FN_DRAW, 3, 9, COL_BLACK, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd131);
        send_request(FN_CLEAR, 0, 0, COL_BLACK, 10'd0);
        send_request(FN_READ, 0, 0, COL_BLACK, 10'd131);

        while (sent_requests < 1000) begin
            pick = $urandom_range(0, 99);
            col  = t_color'($urandom_range(0, 3));
            x    = pick_coordinate(DefWidth);
            y    = pick_coordinate(DefHeight);
            idx  = 10'($urandom);
            if (pick < 55) fn = FN_DRAW;
            else if (pick < 93) fn = FN_READ;
            else if (pick < 97 || clears_left == 0) fn = FN_NONE;
            else fn = FN_CLEAR;

            case (fn)
                FN_DRAW: begin
                    if (x >= 0 && x < DefWidth && y >= 0 && y < DefHeight) begin
                        drawn_bytes.push_back(10'(int'(x) + (int'(y) / 8) * DefWidth));
                        if (drawn_bytes.size() > 16) void'(drawn_bytes.pop_front());
                    end
                end
                FN_READ: begin
                    if (drawn_bytes.size() > 0 && $urandom_range(0, 2) != 0) begin
                        idx = drawn_bytes[$urandom_range(0, drawn_bytes.size() - 1)];
                    end
                end
                FN_CLEAR: begin
                    clears_left--;
                end
                default: ;
            endcase
            send_request(fn, x, y, col, idx);
            sent_requests++;
        end
        start <= 1'b0;

        settle = 0;
        while (reads_outstanding != 0 && settle < 10000) begin
            @(posedge i_clk);
            settle++;
        end
        // a trailing clear may still be filling
        repeat (1100) @(posedge i_clk);

        if (reads_outstanding != 0) begin
            $error("read_data: %0d results never arrived", reads_outstanding);
        end
        if (mismatch_count == 0 && reads_outstanding == 0) begin
            $display("mono_page_framebuffer_unit: match");
        end else begin
            $display("mono_page_framebuffer_unit: mismatch");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("mono_page_framebuffer_unit: mismatch");
        $finish;
    end

endmodule
